// ----- rtl/pst_pkg.sv -----
// Package for the peer sequence table.
// Holds the request, result and table entry types, the action and state codes and the
// shared constants. No dependencies.
package pst_pkg;

  localparam int unsigned PST_ENTRIES = 32;
  localparam logic [31:0] PST_ABSENT  = 32'hFFFF_FFFF;
  localparam logic [31:0] PST_ONE     = 32'd1;

  typedef enum logic [2:0] {
    ACT_CLEAR    = 3'd0,
    ACT_ADD      = 3'd1,
    ACT_REMOVE   = 3'd2,
    ACT_SYNC     = 3'd3,
    ACT_VALIDATE = 3'd4,
    ACT_GET      = 3'd5,
    ACT_GET_ADV  = 3'd6
  } pst_action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_MODIFY,
    ST_BUMP,
    ST_DONE
  } pst_state_t;

  typedef enum logic {
    ALU_LT,
    ALU_BUMP
  } pst_alu_op_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] peer_address;
    logic [31:0] stamp_in;
    logic        last_entry;
  } pst_in_t;

  typedef struct packed {
    logic        peer_found;
    logic        stamp_ok;
    logic [31:0] stamp_out;
    logic [5:0]  entry_count;
    logic        status;
  } pst_out_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] incoming;
    logic [31:0] outgoing;
  } pst_entry_t;

  typedef struct packed {
    logic        lt;
    logic [31:0] bumped;
  } pst_alu_res_t;

endpackage

// ----- rtl/pst_ram.sv -----
// Single-port-write, single-port-read table memory with registered read data.
// Holds both banks of the peer table. Depends on pst_pkg.
module pst_ram
  import pst_pkg::*;
#(
  parameter int unsigned AW = 6
) (
  input  logic       clk,
  input  logic       wr_en,
  input  logic [AW-1:0] wr_addr,
  input  pst_entry_t wr_data,
  input  logic       rd_en,
  input  logic [AW-1:0] rd_addr,
  output pst_entry_t rd_data
);

  pst_entry_t mem [2**AW];
  pst_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/pst_alu.sv -----
// Shared 32-bit adder used for the stale stamp compare and for the wrapping increment.
// Depends on pst_pkg.
module pst_alu
  import pst_pkg::*;
(
  input  pst_alu_op_t  op,
  input  logic [31:0]  a,
  input  logic [31:0]  b,
  output pst_alu_res_t res
);

  logic [32:0] sum;

  assign sum = {1'b0, a} + {1'b0, (op == ALU_LT) ? ~b : 32'd0} + 33'd1;
  assign res.lt = (op == ALU_LT) && !sum[32];
  assign res.bumped = (sum[31:0] == 32'd0) ? PST_ONE : sum[31:0];

endmodule

// ----- rtl/peer_sequence_table_top.sv -----
// Top level of the peer sequence table: sequencer, bank select and result register.
// Depends on pst_pkg, pst_ram and pst_alu.
//
// Usage: requests enter on in_valid/in_ready with an action, a peer address, a stamp
// and a last-entry flag. Each request produces exactly one result on out_valid/out_ready.
// The own address is written on cfg_valid/cfg_ready; the user must write it only while the
// block is idle, since the block itself does not enforce this.
// Every request first scans the live table from index 0, one entry per cycle through
// the table memory's single read port, until a match or the end of the live entries.
// Remove, sync, validate and get then read a table entry for a further step; validate
// and get-advance use the shared adder for the stale compare and the increment.
// One request is in flight at a time; in_ready is low from acceptance until the
// result has been taken. When the receiver stalls, the result is held unchanged.
// Sync entries fill the inactive bank, and the last one swaps banks.
// After reset the table is empty, the own address is 0 and the block is ready at once.
module peer_sequence_table_top
  import pst_pkg::*;
#(
  parameter int unsigned ENTRIES = PST_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  pst_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pst_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  pst_state_t   state_r, state_nxt;
  pst_in_t      req_r, req_nxt;
  logic         found_r, found_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] scan_idx_r, scan_idx_nxt;
  logic         pend_r, pend_nxt;
  logic [IW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [CW-1:0] live_count_r, live_count_nxt;
  logic [CW-1:0] stg_count_r, stg_count_nxt;
  logic         bank_r, bank_nxt;
  logic [31:0]  own_r;
  logic         ok_r, ok_nxt;
  logic [31:0]  sout_r, sout_nxt;
  logic         status_r, status_nxt;

  logic         wr_en, rd_en;
  logic [IW:0]  wr_addr, rd_addr;
  pst_entry_t   wr_data, rd_data;
  pst_alu_op_t  alu_op;
  logic [31:0]  alu_a, alu_b;
  pst_alu_res_t alu_res;
  logic         issue, hit, need_read, stg_full;
  pst_entry_t   ent;

  pst_ram #(.AW(IW + 1)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pst_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign issue    = scan_idx_r < live_count_r;
  assign hit      = pend_r && (rd_data.addr == req_r.peer_address);
  assign stg_full = stg_count_r >= FULL;

  always_comb begin
    case (req_r.action)
      ACT_REMOVE:             need_read = found_r;
      ACT_SYNC:               need_read = !stg_full;
      ACT_VALIDATE:           need_read = found_r && (req_r.stamp_in != 32'd0);
      ACT_GET, ACT_GET_ADV:   need_read = found_r;
      default:                need_read = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (hit || !issue) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = need_read ? ST_MODIFY : ST_DONE;
      end
      ST_MODIFY: begin
        if (req_r.action == ACT_VALIDATE) begin
          state_nxt = alu_res.lt ? ST_DONE : ST_BUMP;
        end else if (req_r.action == ACT_GET_ADV) begin
          state_nxt = ST_BUMP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_BUMP: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    req_nxt        = req_r;
    found_nxt      = found_r;
    idx_nxt        = idx_r;
    scan_idx_nxt   = scan_idx_r;
    pend_nxt       = pend_r;
    cmp_idx_nxt    = cmp_idx_r;
    live_count_nxt = live_count_r;
    stg_count_nxt  = stg_count_r;
    bank_nxt       = bank_r;
    ok_nxt         = ok_r;
    sout_nxt       = sout_r;
    status_nxt     = status_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_addr        = '0;
    alu_op         = ALU_LT;
    alu_a          = req_r.stamp_in;
    alu_b          = rd_data.incoming;
    ent            = rd_data;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        req_nxt      = in_data;
        found_nxt    = 1'b0;
        idx_nxt      = '0;
        scan_idx_nxt = '0;
        pend_nxt     = 1'b0;
        ok_nxt       = 1'b1;
        sout_nxt     = 32'd0;
        status_nxt   = 1'b0;
      end
      ST_SCAN: begin
        rd_en        = issue;
        rd_addr      = {bank_r, scan_idx_r[IW-1:0]};
        pend_nxt     = issue;
        scan_idx_nxt = scan_idx_r + CW'(issue);
        cmp_idx_nxt  = scan_idx_r[IW-1:0];
        if (hit) begin
          found_nxt = 1'b1;
          idx_nxt   = cmp_idx_r;
        end
      end
      ST_EXEC: begin
        rd_en   = need_read;
        rd_addr = {bank_r, idx_r};
        case (req_r.action)
          ACT_CLEAR: begin
            stg_count_nxt  = '0;
            live_count_nxt = CW'(own_r != 32'd0);
            wr_en          = own_r != 32'd0;
            wr_addr        = {bank_r, {IW{1'b0}}};
            wr_data        = '{addr: own_r, incoming: PST_ONE, outgoing: PST_ONE};
          end
          ACT_ADD: begin
            if (live_count_r >= FULL) begin
              status_nxt = 1'b1;
            end else begin
              wr_en          = 1'b1;
              wr_addr        = {bank_r, live_count_r[IW-1:0]};
              wr_data        = '{addr: req_r.peer_address, incoming: PST_ONE,
                                 outgoing: PST_ONE};
              live_count_nxt = live_count_r + CW'(1);
            end
          end
          ACT_REMOVE: begin
            rd_addr = {bank_r, IW'(live_count_r - CW'(1))};
          end
          ACT_SYNC: begin
            if (stg_full) begin
              status_nxt = 1'b1;
              if (req_r.last_entry) begin
                bank_nxt       = !bank_r;
                live_count_nxt = stg_count_r;
                stg_count_nxt  = '0;
              end
            end
          end
          ACT_GET, ACT_GET_ADV: begin
            if (!found_r) sout_nxt = PST_ABSENT;
          end
          default: begin
          end
        endcase
      end
      ST_MODIFY: begin
        case (req_r.action)
          ACT_REMOVE: begin
            wr_en          = 1'b1;
            wr_addr        = {bank_r, idx_r};
            wr_data        = rd_data;
            live_count_nxt = live_count_r - CW'(1);
          end
          ACT_SYNC: begin
            wr_en   = 1'b1;
            wr_addr = {!bank_r, stg_count_r[IW-1:0]};
            wr_data = '{addr: req_r.peer_address,
                        incoming: found_r ? rd_data.incoming : PST_ONE,
                        outgoing: found_r ? rd_data.outgoing : PST_ONE};
            if (req_r.last_entry) begin
              bank_nxt       = !bank_r;
              live_count_nxt = stg_count_r + CW'(1);
              stg_count_nxt  = '0;
            end else begin
              stg_count_nxt = stg_count_r + CW'(1);
            end
          end
          ACT_VALIDATE: begin
            if (alu_res.lt) ok_nxt = 1'b0;
          end
          ACT_GET, ACT_GET_ADV: begin
            sout_nxt = rd_data.outgoing;
          end
          default: begin
          end
        endcase
      end
      ST_BUMP: begin
        alu_op  = ALU_BUMP;
        alu_a   = (req_r.action == ACT_VALIDATE) ? req_r.stamp_in : rd_data.outgoing;
        if (req_r.action == ACT_VALIDATE) begin
          ent.incoming = alu_res.bumped;
        end else begin
          ent.outgoing = alu_res.bumped;
        end
        wr_en   = 1'b1;
        wr_addr = {bank_r, idx_r};
        wr_data = ent;
      end
      ST_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      live_count_r <= '0;
      stg_count_r  <= '0;
      bank_r       <= 1'b0;
      own_r        <= 32'd0;
      pend_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      live_count_r <= live_count_nxt;
      stg_count_r  <= stg_count_nxt;
      bank_r       <= bank_nxt;
      pend_r       <= pend_nxt;
      if (cfg_valid) own_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    found_r    <= found_nxt;
    idx_r      <= idx_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    ok_r       <= ok_nxt;
    sout_r     <= sout_nxt;
    status_r   <= status_nxt;
  end

  assign cfg_ready = 1'b1;

  assign out_data = '{peer_found: found_r, stamp_ok: ok_r, stamp_out: sout_r,
                      entry_count: 6'(live_count_r), status: status_r};

`ifndef NO_ASSERTIONS
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_count_r <= FULL) else $error("Live entry count exceeds the table size.");

  a_stg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stg_count_r <= FULL) else $error("Staging entry count exceeds the table size.");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_EXEC) || (state_r == ST_MODIFY) || (state_r == ST_BUMP))
    else $error("Table write outside an execute step.");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_SCAN) && !out_valid)
    else $error("Accepted request did not start a table scan.");
`endif

endmodule

// ----- test/pst_checker.sv -----
`timescale 1ns / 1ps
// Checker for the peer sequence table: watches the request, result and configuration
// channels, predicts each result and compares it. Depends on pst_pkg.
module pst_checker
  import pst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  pst_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  pst_out_t    out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  logic [31:0] own_addr;
  logic [31:0] live_addr [PST_ENTRIES];
  logic [31:0] live_in [PST_ENTRIES];
  logic [31:0] live_out [PST_ENTRIES];
  int          live_n;
  logic [31:0] stage_addr [PST_ENTRIES];
  logic [31:0] stage_in [PST_ENTRIES];
  logic [31:0] stage_out [PST_ENTRIES];
  int          stage_n;
  pst_out_t    expected_results[$];

  function automatic logic [31:0] next_stamp(logic [31:0] v);
    logic [31:0] n;
    n = v + 32'd1;
    return (n == 32'd0) ? PST_ONE : n;
  endfunction

  task automatic wipe_tables();
    for (int i = 0; i < PST_ENTRIES; i++) begin
      live_addr[i] = '0;
      live_in[i] = PST_ONE;
      live_out[i] = PST_ONE;
    end
    live_n = 0;
    stage_n = 0;
    if (own_addr != 0) begin
      live_addr[0] = own_addr;
      live_n = 1;
    end
  endtask

  task automatic predict_request(pst_in_t req);
    pst_out_t r;
    int idx;
    idx = -1;
    for (int i = 0; i < live_n; i++) begin
      if (idx < 0 && live_addr[i] == req.peer_address) idx = i;
    end
    r = '0;
    r.peer_found = (idx >= 0);
    r.stamp_ok = 1'b1;
    case (req.action)
      ACT_CLEAR: wipe_tables();
      ACT_ADD: begin
        if (live_n >= PST_ENTRIES) begin
          r.status = 1'b1;
        end else begin
          live_addr[live_n] = req.peer_address;
          live_in[live_n] = PST_ONE;
          live_out[live_n] = PST_ONE;
          live_n++;
        end
      end
      ACT_REMOVE: begin
        if (idx >= 0) begin
          live_addr[idx] = live_addr[live_n - 1];
          live_in[idx] = live_in[live_n - 1];
          live_out[idx] = live_out[live_n - 1];
          live_n--;
        end
      end
      ACT_SYNC: begin
        if (stage_n >= PST_ENTRIES) begin
          r.status = 1'b1;
        end else begin
          stage_addr[stage_n] = req.peer_address;
          stage_in[stage_n] = (idx >= 0) ? live_in[idx] : PST_ONE;
          stage_out[stage_n] = (idx >= 0) ? live_out[idx] : PST_ONE;
          stage_n++;
        end
        if (req.last_entry) begin
          for (int i = 0; i < stage_n; i++) begin
            live_addr[i] = stage_addr[i];
            live_in[i] = stage_in[i];
            live_out[i] = stage_out[i];
          end
          live_n = stage_n;
          stage_n = 0;
        end
      end
      ACT_VALIDATE: begin
        if (req.stamp_in != 0 && idx >= 0) begin
          if (req.stamp_in < live_in[idx]) r.stamp_ok = 1'b0;
          else live_in[idx] = next_stamp(req.stamp_in);
        end
      end
      ACT_GET, ACT_GET_ADV: begin
        if (idx < 0) begin
          r.stamp_out = PST_ABSENT;
        end else begin
          r.stamp_out = live_out[idx];
          if (req.action == ACT_GET_ADV) live_out[idx] = next_stamp(live_out[idx]);
        end
      end
      default: ;
    endcase
    r.entry_count = live_n[5:0];
    expected_results.push_back(r);
  endtask

  assign pending = expected_results.size();

  always @(posedge clk) begin
    pst_out_t exp_r;
    if (!rst_n) begin
      own_addr = '0;
      fail_count = 0;
      expected_results.delete();
      wipe_tables();
    end else begin
      if (cfg_valid && cfg_ready) own_addr = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.peer_found !== out_data.peer_found) begin
            $display("%0t: peer_found expected %h actual %h", $time, exp_r.peer_found,
                     out_data.peer_found);
            fail_count++;
          end
          if (exp_r.stamp_ok !== out_data.stamp_ok) begin
            $display("%0t: stamp_ok expected %h actual %h", $time, exp_r.stamp_ok,
                     out_data.stamp_ok);
            fail_count++;
          end
          if (exp_r.stamp_out !== out_data.stamp_out) begin
            $display("%0t: stamp_out expected %h actual %h", $time, exp_r.stamp_out,
                     out_data.stamp_out);
            fail_count++;
          end
          if (exp_r.entry_count !== out_data.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time,
                     exp_r.entry_count, out_data.entry_count);
            fail_count++;
          end
          if (exp_r.status !== out_data.status) begin
            $display("%0t: status expected %h actual %h", $time, exp_r.status,
                     out_data.status);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) predict_request(in_data);
    end
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the peer sequence table: drives requests, configuration and result
// back-pressure; gives the verdict. Depends on pst_pkg, pst_checker, peer_sequence_table_top.
module tb;
  import pst_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  pst_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  pst_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  bit          quiet_phase = 1'b0;
  bit          hold_results = 1'b0;
  int          stall_cycles = 0;
  logic [31:0] peer_pool [8];

  always #5 clk = ~clk;

  peer_sequence_table_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  pst_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (!rst_n || quiet_phase) begin
      out_ready <= rst_n;
    end else if (hold_results) begin
      out_ready <= 1'b0;
    end else if (stall_cycles > 0) begin
      stall_cycles <= stall_cycles - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_cycles <= $urandom_range(1, 9) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic send_request(logic [2:0] act, logic [31:0] addr, logic [31:0] stamp,
                              logic last);
    pst_in_t req;
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      repeat (gap) @(posedge clk);
    end
    req.action = act;
    req.peer_address = addr;
    req.stamp_in = stamp;
    req.last_entry = last;
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_own(logic [31:0] value);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_peer();
    if ($urandom_range(0, 9) == 0) return $urandom();
    return peer_pool[$urandom_range(0, 7)];
  endfunction

  task automatic random_item();
    int kind;
    logic [31:0] stamp;
    kind = $urandom_range(0, 99);
    stamp = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 12);
    if ($urandom_range(0, 30) == 0) stamp = 32'hFFFF_FFFF;
    if (kind < 2) send_request(ACT_CLEAR, $urandom(), $urandom(), 1'($urandom_range(0, 1)));
    else if (kind < 20) send_request(ACT_ADD, pick_peer(), $urandom(),
                                     1'($urandom_range(0, 1)));
    else if (kind < 30) send_request(ACT_REMOVE, pick_peer(), $urandom(), 1'b0);
    else if (kind < 42) send_request(ACT_SYNC, pick_peer(), $urandom(),
                                     $urandom_range(0, 5) == 0);
    else if (kind < 65) send_request(ACT_VALIDATE, pick_peer(), stamp,
                                     1'($urandom_range(0, 1)));
    else if (kind < 78) send_request(ACT_GET, pick_peer(), $urandom(), 1'b0);
    else if (kind < 97) send_request(ACT_GET_ADV, pick_peer(), $urandom(), 1'b1);
    else send_request(3'd7, pick_peer(), $urandom(), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int wait_count;
    for (int i = 0; i < 8; i++) peer_pool[i] = $urandom();
    peer_pool[0] = 32'h0;
    peer_pool[1] = 32'hFFFF_FFFF;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(ACT_GET, 32'h0, 32'h0, 1'b0);
    send_request(ACT_ADD, 32'h0, 32'h0, 1'b0);
    send_request(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_request(ACT_ADD, 32'h0, 32'h0, 1'b0);
    send_request(ACT_VALIDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);
    send_request(ACT_VALIDATE, 32'hFFFF_FFFF, 32'h5, 1'b0);
    send_request(ACT_VALIDATE, 32'hFFFF_FFFF, 32'h0, 1'b0);
    send_request(ACT_VALIDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_request(ACT_VALIDATE, 32'h1234, 32'h7, 1'b0);
    send_request(ACT_GET_ADV, 32'h0, 32'h0, 1'b0);
    send_request(ACT_GET, 32'h0, 32'h0, 1'b0);
    send_request(ACT_GET, 32'h1234, 32'h0, 1'b0);
    send_request(ACT_REMOVE, 32'h0, 32'h0, 1'b0);
    send_request(ACT_REMOVE, 32'h1234, 32'h0, 1'b0);
    send_request(ACT_SYNC, 32'hFFFF_FFFF, 32'h0, 1'b0);
    send_request(ACT_SYNC, 32'hABCD, 32'h0, 1'b1);
    send_request(3'd7, 32'hABCD, 32'hFFFF_FFFF, 1'b1);
    for (int i = 0; i < 33; i++) send_request(ACT_ADD, i, 32'h0, 1'b0);
    for (int i = 0; i < 33; i++) send_request(ACT_SYNC, i, 32'h0, i == 32);
    write_own(32'hFFFF_FFFF);
    send_request(ACT_CLEAR, 32'h0, 32'h0, 1'b0);
    send_request(ACT_GET_ADV, 32'hFFFF_FFFF, 32'h0, 1'b0);

    for (int i = 0; i < 1050; i++) begin
      if (i == 350) write_own(32'h0);
      if (i == 700) write_own(peer_pool[$urandom_range(2, 7)]);
      if (i == 900) quiet_phase = 1'b1;
      if (i == 200) begin
        hold_results = 1'b1;
        fork
          begin
            wait_count = 0;
            while (wait_count < 400) begin
              @(posedge clk);
              wait_count++;
            end
            hold_results = 1'b0;
          end
        join_none
      end
      random_item();
    end

    wait_count = 0;
    while (pending != 0 && wait_count < 100000) begin
      @(posedge clk);
      wait_count++;
    end
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
